// ===== rtl/xytlp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the XY target line parser: line store geometry and character codes.
// No dependencies; the core refers to these by scoped names.
package xytlp_pkg;

  localparam int LINE_BYTES = 64;
  localparam int IDX_W      = $clog2(LINE_BYTES);
  // Scan position may step two past the last entry.
  localparam int POS_W      = $clog2(LINE_BYTES + 2);

  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_X  = 8'h58;
  localparam logic [7:0] CH_Y  = 8'h59;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic [3:0] DIGIT_SCALE = 4'd10;

endpackage

// ===== rtl/xy_target_line_parser_core.sv =====
`timescale 1ns / 1ps
// XY target line parser core: line store memory plus the line-end scan sequencer.
// Depends on xytlp_pkg for store geometry and character codes.
//
// Flow: a plain byte is written into the store. A terminator that closes a non-empty line
//   starts a scan that reads and then evaluates each visited position: position 0 for E,
//   then a search for X and one for Y, each ending at the end of its number, at a NUL or
//   off the store; the result then waits for the output register while the output stalls.
// Throughput: one byte per cycle between terminators; no new byte during a scan or while the result waits.
// Reset: asynchronous, active low; clears index, sequencer, output valid, entry valid bits.
module xy_target_line_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               cmd_kind_o,
  output logic signed [31:0] x_target_o,
  output logic signed [31:0] y_target_o
);

  localparam int IDX_W = xytlp_pkg::IDX_W;
  localparam int POS_W = xytlp_pkg::POS_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_E_RD    = 3'd1;  // read position 0
  localparam logic [2:0] S_E_EV    = 3'd2;  // check for emergency stop
  localparam logic [2:0] S_FIND_RD = 3'd3;  // read next candidate key position
  localparam logic [2:0] S_FIND_EV = 3'd4;  // compare against key / terminator
  localparam logic [2:0] S_DIG_RD  = 3'd5;  // read next digit position
  localparam logic [2:0] S_DIG_EV  = 3'd6;  // accumulate or end the number
  localparam logic [2:0] S_OUT     = 3'd7;  // hand the result to the output register

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             phase_q, phase_d;   // 0: scanning for X, 1: scanning for Y
  logic             estop_q, estop_d;
  logic [31:0]      acc_q, acc_d;
  logic [31:0]      x_acc_q, x_acc_d;

  // Line store and its read path.
  logic [7:0]            mem [xytlp_pkg::LINE_BYTES];
  logic                  valid_q [xytlp_pkg::LINE_BYTES];
  logic [7:0]            rd_data_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_addr;
  logic                  we;
  logic [7:0]            wdata;
  logic [7:0]            rd_byte;

  logic in_acc;
  logic is_term;
  logic out_load;
  logic out_valid_q;
  logic finish;
  logic pos_oor;
  logic [7:0]  key;
  logic [31:0] acc_next;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_term     = (rx_byte_i == xytlp_pkg::CH_LF) || (rx_byte_i == xytlp_pkg::CH_CR);
  assign we          = in_acc;
  assign wdata       = is_term ? xytlp_pkg::CH_NUL : rx_byte_i;
  assign rd_addr     = pos_q[IDX_W-1:0];
  // Never-written entries read as zero, as if the store had been cleared.
  assign rd_byte     = rd_vld_q ? rd_data_q : xytlp_pkg::CH_NUL;
  assign pos_oor     = (pos_q >= POS_W'(xytlp_pkg::LINE_BYTES));
  assign key         = phase_q ? xytlp_pkg::CH_Y : xytlp_pkg::CH_X;
  // acc * 10 + digit, wrapping modulo 2^32.
  assign acc_next    = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, rd_byte[3:0]};
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_idx_q] <= wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < xytlp_pkg::LINE_BYTES; i++) begin
        valid_q[i] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
    end else begin
      if (we) begin
        valid_q[wr_idx_q] <= 1'b1;
      end
      rd_vld_q <= valid_q[rd_addr];
    end
  end

  always_comb begin
    state_d  = state_q;
    wr_idx_d = wr_idx_q;
    pos_d    = pos_q;
    phase_d  = phase_q;
    estop_d  = estop_q;
    acc_d    = acc_q;
    x_acc_d  = x_acc_q;
    finish   = 1'b0;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (is_term) begin
            wr_idx_d = '0;
            if (wr_idx_q != '0) begin
              pos_d   = '0;
              state_d = S_E_RD;
            end
          end else if (wr_idx_q == IDX_W'(xytlp_pkg::LINE_BYTES - 1)) begin
            wr_idx_d = '0;
          end else begin
            wr_idx_d = wr_idx_q + IDX_W'(1);
          end
        end
      end
      S_E_RD: begin
        state_d = S_E_EV;
      end
      S_E_EV: begin
        if (rd_byte == xytlp_pkg::CH_E) begin
          estop_d = 1'b1;
          x_acc_d = '0;
          acc_d   = '0;
          state_d = S_OUT;
        end else begin
          estop_d = 1'b0;
          phase_d = 1'b0;
          pos_d   = '0;
          state_d = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        if (pos_oor) begin
          acc_d  = '0;
          finish = 1'b1;
        end else begin
          state_d = S_FIND_EV;
        end
      end
      S_FIND_EV: begin
        if (rd_byte == key) begin
          // Skip the key and the separator after it.
          pos_d   = pos_q + POS_W'(2);
          acc_d   = '0;
          state_d = S_DIG_RD;
        end else if (rd_byte == xytlp_pkg::CH_NUL) begin
          acc_d  = '0;
          finish = 1'b1;
        end else begin
          pos_d   = pos_q + POS_W'(1);
          state_d = S_FIND_RD;
        end
      end
      S_DIG_RD: begin
        if (pos_oor) begin
          finish = 1'b1;
        end else begin
          state_d = S_DIG_EV;
        end
      end
      S_DIG_EV: begin
        if (rd_byte >= xytlp_pkg::CH_0 && rd_byte <= xytlp_pkg::CH_9) begin
          acc_d   = acc_next;
          pos_d   = pos_q + POS_W'(1);
          state_d = S_DIG_RD;
        end else begin
          finish = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // End of one key search: latch X and restart for Y, or finish the line.
    if (finish) begin
      if (!phase_q) begin
        x_acc_d = acc_d;
        phase_d = 1'b1;
        pos_d   = '0;
        state_d = S_FIND_RD;
      end else begin
        state_d = S_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_idx_q    <= '0;
      pos_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_idx_q <= wr_idx_d;
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    estop_q <= estop_d;
    acc_q   <= acc_d;
    x_acc_q <= x_acc_d;
    if (out_load) begin
      cmd_kind_o <= estop_q;
      x_target_o <= estop_q ? '0 : signed'(x_acc_q);
      y_target_o <= estop_q ? '0 : signed'(acc_q);
    end
  end

  // Write index stays inside the store.
  a_wr_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, wr_idx_q} < (IDX_W + 1)'(xytlp_pkg::LINE_BYTES))
    else $error("write index out of range");

  // Scan position never runs further than two past the last store entry.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(xytlp_pkg::LINE_BYTES + 1))
    else $error("scan position out of range");

  // A terminator closing a non-empty line starts the scan and resets the index.
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_term && (wr_idx_q != '0) |=> (state_q == S_E_RD) && (wr_idx_q == '0))
    else $error("scan did not start on terminator");

  // The finished result waits while the output register is still taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && out_valid_q && out_stall_i |=> (state_q == S_OUT))
    else $error("result overwrote a waiting item");

  // Emergency stop carries zero targets.
  a_estop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && cmd_kind_o |-> (x_target_o == '0) && (y_target_o == '0))
    else $error("emergency stop with nonzero targets");

endmodule
